// ===== design/spimb_pkg.sv =====
package spimb_pkg;

  localparam int unsigned DATA_BITS  = 8;
  localparam int unsigned EDGE_W     = $clog2(2 * DATA_BITS);
  localparam int unsigned DIV_W      = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [3:0]  MAX_RATE   = 4'd8;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_READ   = 2'd2,
    REQ_STATUS = 2'd3
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 3'd0,
    CFG_CPOL     = 3'd1,
    CFG_CPHA     = 3'd2,
    CFG_PRESCALE = 3'd3,
    CFG_RATE     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic       enable;
    logic       cpol;
    logic       cpha;
    logic [2:0] prescale_sel;
    logic [3:0] rate_sel;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [DATA_BITS-1:0] wr_data;
    logic                 miso_bit;
  } req_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] rd_data;
    logic                 tx_empty;
    logic                 rx_full;
    logic                 sclk;
    logic                 mosi;
    logic                 cs_n;
  } rsp_t;

endpackage

// ===== design/spimb_if.sv =====
interface spimb_req_if;
  import spimb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [DATA_BITS-1:0] wr_data;
  logic                 miso_bit;

  modport source (output valid, req_type, wr_data, miso_bit, input ready);
  modport sink (input valid, req_type, wr_data, miso_bit, output ready);
endinterface

interface spimb_rsp_if;
  import spimb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DATA_BITS-1:0] rd_data;
  logic                 tx_empty;
  logic                 rx_full;
  logic                 sclk;
  logic                 mosi;
  logic                 cs_n;

  modport source (output valid, rd_data, tx_empty, rx_full, sclk, mosi, cs_n, input ready);
  modport sink (input valid, rd_data, tx_empty, rx_full, sclk, mosi, cs_n, output ready);
endinterface

// ===== design/spi_master_byte_transfer.sv =====
// SPI master for modes 0 to 3 behind a small register interface. Each request word is
// one bus clock tick, a data write, a data read or a status read, and every request
// gives exactly one response word carrying the data read and the line and flag state
// after that request. A request is taken every cycle while the response register is
// empty or being drained; the response is registered on acceptance and appears in the
// next cycle, taken from the next-state values of the transfer state. The SCK
// half-period is (prescale_sel+1)*2^min(rate_sel,8) ticks; register accesses do not
// advance it. A written byte waits in a one-entry buffer and starts shifting, MSB
// first, on the next tick with no transfer running; cs_n drops for the byte. A byte
// received while rx_full is set is dropped. Write the configuration only while idle.
module spi_master_byte_transfer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [spimb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [spimb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  spimb_req_if.sink                         req_i,
  spimb_rsp_if.source                       rsp_o
);
  import spimb_pkg::*;

  cfg_t cfg;
  logic clear;
  logic acc;
  req_t req;
  rsp_t rsp_next;
  rsp_t rsp_q;
  logic out_vld_q;

  assign req_i.ready = !out_vld_q || rsp_o.ready;
  assign acc         = req_i.valid && req_i.ready;
  assign req         = '{req_type: req_i.req_type, wr_data: req_i.wr_data,
                         miso_bit: req_i.miso_bit};

  spimb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .clear_o    (clear)
  );

  spimb_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .clear_i (clear),
    .acc_i   (acc),
    .req_i   (req),
    .rsp_o   (rsp_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (acc) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // hold the word while the sink stalls
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.rd_data  = rsp_q.rd_data;
  assign rsp_o.tx_empty = rsp_q.tx_empty;
  assign rsp_o.rx_full  = rsp_q.rx_full;
  assign rsp_o.sclk     = rsp_q.sclk;
  assign rsp_o.mosi     = rsp_q.mosi;
  assign rsp_o.cs_n     = rsp_q.cs_n;

`ifndef SYNTH
  a_accept_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_vld_q)
    else $error("accepted request produced no response word");
`endif

endmodule

// ===== design/spimb_regs.sv =====
module spimb_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [spimb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [spimb_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output spimb_pkg::cfg_t                     cfg_o,
  output logic                                clear_o
);
  import spimb_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d   = cfg_q;
    clear_o = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE: begin
          cfg_d.enable = cfg_data_i[0];
          clear_o      = !cfg_data_i[0];
        end
        CFG_CPOL:     cfg_d.cpol         = cfg_data_i[0];
        CFG_CPHA:     cfg_d.cpha         = cfg_data_i[0];
        CFG_PRESCALE: cfg_d.prescale_sel = cfg_data_i[2:0];
        CFG_RATE:     cfg_d.rate_sel     = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{enable: 1'b0, cpol: 1'b0, cpha: 1'b1, prescale_sel: 3'd0, rate_sel: 4'd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/spimb_engine.sv =====
module spimb_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  spimb_pkg::cfg_t  cfg_i,
  input  logic             clear_i,
  input  logic             acc_i,
  input  spimb_pkg::req_t  req_i,
  output spimb_pkg::rsp_t  rsp_o
);
  import spimb_pkg::*;

  logic [DATA_BITS-1:0] tx_hold_q, tx_hold_d;
  logic                 tx_vld_q, tx_vld_d;
  logic [DATA_BITS-1:0] shift_q, shift_d;
  logic [DATA_BITS-1:0] rx_hold_q, rx_hold_d;
  logic                 rx_vld_q, rx_vld_d;
  logic [EDGE_W-1:0]    edge_q, edge_d;
  logic [DIV_W-1:0]     div_q, div_d;
  logic                 lvl_q, lvl_d;
  logic                 busy_q, busy_d;
  logic                 mosi_q, mosi_d;

  logic [3:0]       rate_eff;
  logic [DIV_W-1:0] half_period;
  logic             div_done;
  logic             sample;
  logic             is_tick;

  assign rate_eff    = (cfg_i.rate_sel > MAX_RATE) ? MAX_RATE : cfg_i.rate_sel;
  assign half_period = DIV_W'({1'b0, cfg_i.prescale_sel} + 4'd1) << rate_eff;
  assign div_done    = ({1'b0, div_q} + (DIV_W+1)'(1)) >= {1'b0, half_period};
  // leading edges are the even ones; cpha flips which edge samples
  assign sample      = !edge_q[0] ^ cfg_i.cpha;
  assign is_tick     = acc_i && (req_type_e'(req_i.req_type) == REQ_TICK) && cfg_i.enable;

  always_comb begin
    tx_hold_d = tx_hold_q;
    tx_vld_d  = tx_vld_q;
    shift_d   = shift_q;
    rx_hold_d = rx_hold_q;
    rx_vld_d  = rx_vld_q;
    edge_d    = edge_q;
    div_d     = div_q;
    lvl_d     = lvl_q;
    busy_d    = busy_q;
    mosi_d    = mosi_q;

    if (is_tick) begin
      if (!busy_q) begin
        // load the buffered word into the shifter
        if (tx_vld_q) begin
          shift_d  = tx_hold_q;
          tx_vld_d = 1'b0;
          busy_d   = 1'b1;
          edge_d   = '0;
          div_d    = '0;
          lvl_d    = cfg_i.cpol;
          if (!cfg_i.cpha) begin
            mosi_d = tx_hold_q[DATA_BITS-1];
          end
        end
      end else if (div_done) begin
        div_d = '0;
        lvl_d = !lvl_q;
        if (sample) begin
          shift_d = {shift_q[DATA_BITS-2:0], req_i.miso_bit};
        end else begin
          mosi_d = shift_q[DATA_BITS-1];
        end
        if (edge_q == EDGE_W'(2 * DATA_BITS - 1)) begin
          // drop the word on overrun
          if (!rx_vld_q) begin
            rx_hold_d = shift_d;
            rx_vld_d  = 1'b1;
          end
          busy_d = 1'b0;
          edge_d = '0;
          lvl_d  = cfg_i.cpol;
        end else begin
          edge_d = edge_q + EDGE_W'(1);
        end
      end else begin
        div_d = div_q + DIV_W'(1);
      end
    end else if (acc_i) begin
      unique case (req_type_e'(req_i.req_type))
        REQ_WRITE: begin
          if (cfg_i.enable && !tx_vld_q) begin
            tx_hold_d = req_i.wr_data;
            tx_vld_d  = 1'b1;
          end
        end
        REQ_READ: rx_vld_d = 1'b0;
        default: ;
      endcase
    end

    if (clear_i) begin
      tx_vld_d = 1'b0;
      rx_vld_d = 1'b0;
      busy_d   = 1'b0;
      edge_d   = '0;
      div_d    = '0;
      lvl_d    = cfg_i.cpol;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_hold_q <= '0;
      tx_vld_q  <= 1'b0;
      shift_q   <= '0;
      rx_hold_q <= '0;
      rx_vld_q  <= 1'b0;
      edge_q    <= '0;
      div_q     <= '0;
      lvl_q     <= 1'b0;
      busy_q    <= 1'b0;
      mosi_q    <= 1'b0;
    end else begin
      tx_hold_q <= tx_hold_d;
      tx_vld_q  <= tx_vld_d;
      shift_q   <= shift_d;
      rx_hold_q <= rx_hold_d;
      rx_vld_q  <= rx_vld_d;
      edge_q    <= edge_d;
      div_q     <= div_d;
      lvl_q     <= lvl_d;
      busy_q    <= busy_d;
      mosi_q    <= mosi_d;
    end
  end

  always_comb begin
    rsp_o.rd_data  = (acc_i && (req_type_e'(req_i.req_type) == REQ_READ)) ? rx_hold_q : '0;
    rsp_o.tx_empty = cfg_i.enable && !tx_vld_d;
    rsp_o.rx_full  = rx_vld_d;
    rsp_o.sclk     = busy_d ? lvl_d : cfg_i.cpol;
    rsp_o.mosi     = mosi_d;
    rsp_o.cs_n     = !busy_d;
  end

`ifndef SYNTH
  a_idle_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (div_q == '0) && (edge_q == '0))
    else $error("divider or edge count left running while idle");

  a_disabled_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_i.enable |-> !busy_q && !tx_vld_q && !rx_vld_q)
    else $error("transfer state set while disabled");

  a_start_takes_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(tx_vld_q) && !tx_vld_q)
    else $error("transfer started without a buffered word");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spimb_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  spimb_req_if req_if ();
  spimb_rsp_if rsp_if ();

  spi_master_byte_transfer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  req_t        word_q[$];
  rsp_t        expect_q[$];
  logic        word_taken = 1'b0;
  int          send_gap_pct;
  int          rcv_stall_pct;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;

  // Shadow of the SPI master state and its registers
  cfg_t                 cfg_m = '{enable: 1'b0, cpol: 1'b0, cpha: 1'b1,
                                  prescale_sel: 3'd0, rate_sel: 4'd0};
  logic [DATA_BITS-1:0] tx_buf = '0;
  logic [DATA_BITS-1:0] shifter = '0;
  logic [DATA_BITS-1:0] rx_buf = '0;
  logic                 tx_loaded = 1'b0;
  logic                 rx_waiting = 1'b0;
  logic [4:0]           edge_idx = '0;
  int unsigned          div_cnt = 0;
  logic                 sck_level = 1'b0;
  logic                 shifting = 1'b0;
  logic                 mosi_q = 1'b0;

  function automatic rsp_t spi_predict(req_t w);
    rsp_t        o;
    int unsigned half_per;
    logic        sample_now;
    o = '0;
    half_per = (int'(cfg_m.prescale_sel) + 1) <<
               ((cfg_m.rate_sel > MAX_RATE) ? MAX_RATE : cfg_m.rate_sel);
    case (req_type_e'(w.req_type))
      REQ_TICK: begin
        if (cfg_m.enable) begin
          if (!shifting) begin
            // load the shifter; the first edge comes on a later tick
            if (tx_loaded) begin
              shifter = tx_buf;
              tx_loaded = 1'b0;
              shifting = 1'b1;
              edge_idx = '0;
              div_cnt = 0;
              sck_level = cfg_m.cpol;
              if (!cfg_m.cpha) mosi_q = shifter[DATA_BITS-1];
            end
          end else if (div_cnt + 1 >= half_per) begin
            div_cnt = 0;
            sample_now = cfg_m.cpha ? edge_idx[0] : !edge_idx[0];
            sck_level = !sck_level;
            if (sample_now) shifter = {shifter[DATA_BITS-2:0], w.miso_bit};
            else mosi_q = shifter[DATA_BITS-1];
            if (edge_idx >= 2 * DATA_BITS - 1) begin
              // drop the byte on overrun
              if (!rx_waiting) begin
                rx_buf = shifter;
                rx_waiting = 1'b1;
              end
              shifting = 1'b0;
              edge_idx = '0;
              div_cnt = 0;
              sck_level = cfg_m.cpol;
            end else begin
              edge_idx++;
            end
          end else begin
            div_cnt++;
          end
        end
      end
      REQ_WRITE: begin
        if (cfg_m.enable && !tx_loaded) begin
          tx_buf = w.wr_data;
          tx_loaded = 1'b1;
        end
      end
      REQ_READ: begin
        o.rd_data = rx_buf;
        rx_waiting = 1'b0;
      end
      default: ;
    endcase
    o.tx_empty = cfg_m.enable && !tx_loaded;
    o.rx_full  = rx_waiting;
    o.sclk     = shifting ? sck_level : cfg_m.cpol;
    o.mosi     = mosi_q;
    o.cs_n     = !shifting;
    return o;
  endfunction

  function automatic req_t word_of(req_type_e t, logic [DATA_BITS-1:0] d, logic m);
    req_t w;
    w.req_type = t;
    w.wr_data  = d;
    w.miso_bit = m;
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_BITS-1:0] got,
                                 logic [DATA_BITS-1:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Write one register and mirror it once the write edge has passed
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ENABLE: begin
        cfg_m.enable = val[0];
        if (!val[0]) begin
          tx_loaded = 1'b0;
          rx_waiting = 1'b0;
          shifting = 1'b0;
          edge_idx = '0;
          div_cnt = 0;
          sck_level = cfg_m.cpol;
        end
      end
      CFG_CPOL: begin
        cfg_m.cpol = val[0];
        if (!shifting) sck_level = val[0];
      end
      CFG_CPHA:     cfg_m.cpha = val[0];
      CFG_PRESCALE: cfg_m.prescale_sel = val[2:0];
      CFG_RATE:     cfg_m.rate_sel = val;
      default: ;
    endcase
  endtask

  // Unused upper bits get random values
  task automatic set_mode(logic en, logic pol, logic pha, logic [2:0] pre, logic [3:0] rate);
    write_reg(CFG_ENABLE, {3'($urandom_range(7)), en});
    write_reg(CFG_CPOL, {3'($urandom_range(7)), pol});
    write_reg(CFG_CPHA, {3'($urandom_range(7)), pha});
    write_reg(CFG_PRESCALE, {1'($urandom_range(1)), pre});
    write_reg(CFG_RATE, rate);
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (word_q.size() != 0 || req_if.valid || expect_q.size() != 0);
  endtask

  task automatic run_random(int n);
    int unsigned pick;
    req_type_e   t;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 70) t = REQ_TICK;
      else if (pick < 82) t = REQ_WRITE;
      else if (pick < 92) t = REQ_READ;
      else t = REQ_STATUS;
      word_q.push_back(word_of(t, 8'($urandom_range(255)), 1'($urandom_range(1))));
    end
    wait_drained();
  endtask

  always @(negedge clk_i) begin : drive
    req_t w;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      rsp_if.ready <= 1'b0;
    end else begin
      if (!req_if.valid || word_taken) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          w = word_q.pop_front();
          req_if.valid    <= 1'b1;
          req_if.req_type <= w.req_type;
          req_if.wr_data  <= w.wr_data;
          req_if.miso_bit <= w.miso_bit;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watch
    req_t w;
    rsp_t got;
    rsp_t want;
    if (rst_ni) begin
      word_taken <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        w.req_type = req_if.req_type;
        w.wr_data  = req_if.wr_data;
        w.miso_bit = req_if.miso_bit;
        expect_q.push_back(spi_predict(w));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got.rd_data  = rsp_if.rd_data;
        got.tx_empty = rsp_if.tx_empty;
        got.rx_full  = rsp_if.rx_full;
        got.sclk     = rsp_if.sclk;
        got.mosi     = rsp_if.mosi;
        got.cs_n     = rsp_if.cs_n;
        if (expect_q.size() == 0) begin
          report_mismatch("unexpected word", got.rd_data, '0);
        end else begin
          want = expect_q.pop_front();
          if (got.rd_data !== want.rd_data) report_mismatch("rd_data", got.rd_data, want.rd_data);
          if (got.tx_empty !== want.tx_empty)
            report_mismatch("tx_empty", 8'(got.tx_empty), 8'(want.tx_empty));
          if (got.rx_full !== want.rx_full)
            report_mismatch("rx_full", 8'(got.rx_full), 8'(want.rx_full));
          if (got.sclk !== want.sclk)
            report_mismatch("sclk", 8'(got.sclk), 8'(want.sclk));
          if (got.mosi !== want.mosi)
            report_mismatch("mosi", 8'(got.mosi), 8'(want.mosi));
          if (got.cs_n !== want.cs_n)
            report_mismatch("cs_n", 8'(got.cs_n), 8'(want.cs_n));
        end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_TICK;
    req_if.wr_data  = '0;
    req_if.miso_bit = 1'b0;
    rsp_if.ready    = 1'b0;
    send_gap_pct    = 32;
    rcv_stall_pct   = 60;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Disabled after reset: writes and ticks are ignored, read gives zero
    word_q.push_back(word_of(REQ_WRITE, 8'hA5, 1'b1));
    word_q.push_back(word_of(REQ_TICK, 8'h5A, 1'b1));
    word_q.push_back(word_of(REQ_READ, 8'h00, 1'b0));
    word_q.push_back(word_of(REQ_STATUS, 8'hFF, 1'b0));
    wait_drained();

    // One full byte in mode 0; the second write hits a full buffer
    set_mode(1'b1, 1'b0, 1'b0, 3'd0, 4'd0);
    word_q.push_back(word_of(REQ_WRITE, 8'hFF, 1'b0));
    word_q.push_back(word_of(REQ_WRITE, 8'h00, 1'b1));
    for (int k = 0; k < 17; k++) word_q.push_back(word_of(REQ_TICK, 8'h00, k[0]));
    word_q.push_back(word_of(REQ_READ, 8'hFF, 1'b1));
    word_q.push_back(word_of(REQ_READ, 8'h00, 1'b0));
    wait_drained();

    run_random(100);
    run_random(100);
    set_mode(1'b1, 1'b0, 1'b1, 3'd0, 4'd2);
    run_random(200);

    send_gap_pct  = 60;
    rcv_stall_pct = 32;
    set_mode(1'b1, 1'b1, 1'b0, 3'd3, 4'd1);
    run_random(200);
    set_mode(1'b1, 1'b1, 1'b1, 3'd7, 4'd0);
    run_random(200);

    // Slowest divider; rate above the clamp; shorten it while a byte is in flight
    send_gap_pct  = 0;
    rcv_stall_pct = 0;
    set_mode(1'b1, 1'b0, 1'b1, 3'd7, 4'd15);
    word_q.push_back(word_of(REQ_WRITE, 8'($urandom_range(255)), 1'b0));
    word_q.push_back(word_of(REQ_TICK, 8'h00, 1'b0));
    run_random(150);
    set_mode(1'b1, 1'b1, 1'b0, 3'd0, 4'd0);
    run_random(150);

    for (int k = int'(CFG_RATE) + 1; k < 2 ** CFG_IDX_W; k++) begin
      write_reg(k[CFG_IDX_W-1:0], 4'($urandom_range(15)));
    end
    word_q.push_back(word_of(REQ_WRITE, 8'h3C, 1'b0));
    word_q.push_back(word_of(REQ_TICK, 8'h00, 1'b0));
    word_q.push_back(word_of(REQ_TICK, 8'h00, 1'b1));
    wait_drained();

    // Disable mid-transfer, then come back in mode 2
    write_reg(CFG_ENABLE, {3'($urandom_range(7)), 1'b0});
    run_random(40);
    set_mode(1'b1, 1'b1, 1'b0, 3'd1, 4'd1);
    run_random(150);

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
